### design/wss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types, constants and helpers of the wildcard signature scan unit.
// ----------------------------------------------------------------------------
package wss_pkg;

    localparam int PATTERN_BYTES_DEF = 16;
    localparam int PATTERN_COUNT_DEF = 2;
    localparam int OFFSET_BITS_DEF   = 32;

    localparam int CFG_PATTERNS = 2;
    localparam int REG_BYTES    = 16;
    localparam int BYTE_W       = 8;
    localparam int CARE_W       = 16;
    localparam int LEN_W        = 5;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 4;
    localparam int HIT_OFFSET_W = 32;
    localparam int HIT_COUNT_W  = 8;
    localparam int STATUS_W     = 2;
    localparam int PAT_W        = REG_BYTES * BYTE_W;

    localparam logic [HIT_COUNT_W-1:0] HIT_COUNT_MAX = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_P0_LOW  = 4'd0,
        REG_P0_HIGH = 4'd1,
        REG_P1_LOW  = 4'd2,
        REG_P1_HIGH = 4'd3,
        REG_P0_CARE = 4'd4,
        REG_P1_CARE = 4'd5,
        REG_P0_LEN  = 4'd6,
        REG_P1_LEN  = 4'd7
    } cfg_reg_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_NONE      = 2'd0,
        STATUS_UNIQUE    = 2'd1,
        STATUS_AMBIGUOUS = 2'd2
    } scan_status_t;

    typedef struct packed {
        scan_status_t            status;
        logic [HIT_OFFSET_W-1:0] offset;
        logic [HIT_COUNT_W-1:0]  count;
    } scan_result_t;

    function automatic logic [BYTE_W-1:0] pattern_byte(input logic [PAT_W-1:0] bytes,
                                                       input logic [3:0] idx);
        logic [PAT_W-1:0] shifted;
        shifted = bytes >> {idx, 3'b000};
        return shifted[BYTE_W-1:0];
    endfunction

endpackage

### design/wss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_cell
// One window position: holds a byte, its start mark and its counted mark,
// passes them on each accepted word and compares the incoming byte against
// the pattern byte aligned to this position.
// ----------------------------------------------------------------------------
module wss_cell
    import wss_pkg::*;
#(
    parameter int PATTERN_COUNT = PATTERN_COUNT_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step,
    input  logic                                 clear,
    input  logic [BYTE_W-1:0]                    in_byte,
    input  logic                                 in_allowed,
    input  logic                                 in_counted,
    input  logic                                 set_counted,
    input  logic [PATTERN_COUNT-1:0][BYTE_W-1:0] expect_byte,
    input  logic [PATTERN_COUNT-1:0]             care,
    output logic [BYTE_W-1:0]                    byte_q,
    output logic                                 allowed_q,
    output logic                                 counted_q,
    output logic [PATTERN_COUNT-1:0]             mismatch
);

    logic [BYTE_W-1:0] byte_reg;
    logic              allowed_reg;
    logic              counted_reg;
    logic              allowed_next;
    logic              counted_next;

    always_comb
    begin
        for (int p = 0; p < PATTERN_COUNT; p++)
        begin
            mismatch[p] = care[p] && (in_byte != expect_byte[p]);
        end
    end

    always_comb
    begin
        allowed_next = allowed_reg;
        counted_next = counted_reg;
        if (step)
        begin
            allowed_next = clear ? 1'b0 : in_allowed;
            counted_next = clear ? 1'b0 : (in_counted | set_counted);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else if (step)
        begin
            byte_reg <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allowed_reg <= 1'b0;
            counted_reg <= 1'b0;
        end
        else
        begin
            allowed_reg <= allowed_next;
            counted_reg <= counted_next;
        end
    end

    assign byte_q    = byte_reg;
    assign allowed_q = allowed_reg;
    assign counted_q = counted_reg;

endmodule

### design/wss_tally.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_tally
// Hit resolution per pattern, byte offset, saturating hit count and lowest
// hit offset; builds the region result on the final word.
// ----------------------------------------------------------------------------
module wss_tally
    import wss_pkg::*;
#(
    parameter int PATTERN_BYTES = PATTERN_BYTES_DEF,
    parameter int PATTERN_COUNT = PATTERN_COUNT_DEF,
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
    parameter int CELL_IDX_W    = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     step,
    input  logic                                     last,
    input  logic [PATTERN_COUNT-1:0]                 enable,
    input  logic [PATTERN_COUNT-1:0][CELL_IDX_W-1:0] tap,
    input  logic [PATTERN_COUNT-1:0][PATTERN_BYTES-1:0] mismatch,
    input  logic [PATTERN_BYTES-1:0]                 allowed_in,
    input  logic [PATTERN_BYTES-1:0]                 counted_in,
    output logic [PATTERN_BYTES-1:0]                 set_counted,
    output scan_result_t                             result
);

    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;
    logic [HIT_COUNT_W-1:0] hits_reg;
    logic [HIT_COUNT_W-1:0] hits_next;
    logic [OFFSET_BITS-1:0] first_reg;
    logic [OFFSET_BITS-1:0] first_next;
    logic [HIT_COUNT_W-1:0] hits_acc;
    logic [OFFSET_BITS-1:0] first_acc;
    logic [PATTERN_COUNT-1:0] hit;
    logic [OFFSET_BITS+HIT_OFFSET_W-1:0] first_wide;

    always_comb
    begin
        logic                   cand;
        logic [OFFSET_BITS-1:0] start;
        hits_acc  = hits_reg;
        first_acc = first_reg;
        hit       = '0;
        for (int p = 0; p < PATTERN_COUNT; p++)
        begin
            cand = enable[p] && allowed_in[tap[p]] && !counted_in[tap[p]]
                   && !(|mismatch[p]);
            for (int q = 0; q < PATTERN_COUNT; q++)
            begin
                if (q < p && hit[q] && (tap[q] == tap[p]))
                begin
                    cand = 1'b0;
                end
            end
            hit[p] = cand;
            start  = pos_reg - OFFSET_BITS'(tap[p]);
            if (cand)
            begin
                if ((hits_acc == '0) || (start < first_acc))
                begin
                    first_acc = start;
                end
                if (hits_acc != HIT_COUNT_MAX)
                begin
                    hits_acc = hits_acc + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < PATTERN_BYTES; j++)
        begin
            set_counted[j] = 1'b0;
            for (int p = 0; p < PATTERN_COUNT; p++)
            begin
                if (hit[p] && (int'(tap[p]) == j))
                begin
                    set_counted[j] = 1'b1;
                end
            end
        end
    end

    assign first_wide = {{HIT_OFFSET_W{1'b0}}, first_acc};

    always_comb
    begin
        result.count  = hits_acc;
        result.offset = (hits_acc == '0) ? '0 : first_wide[HIT_OFFSET_W-1:0];
        priority if (hits_acc == '0)
        begin
            result.status = STATUS_NONE;
        end
        else if (hits_acc == HIT_COUNT_W'(1))
        begin
            result.status = STATUS_UNIQUE;
        end
        else
        begin
            result.status = STATUS_AMBIGUOUS;
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        hits_next  = hits_reg;
        first_next = first_reg;
        if (step)
        begin
            if (last)
            begin
                pos_next   = '0;
                hits_next  = '0;
                first_next = '0;
            end
            else
            begin
                pos_next   = pos_reg + 1'b1;
                hits_next  = hits_acc;
                first_next = first_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            hits_reg  <= '0;
            first_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            hits_reg  <= hits_next;
            first_reg <= first_next;
        end
    end

endmodule

### design/wildcard_signature_scan_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_signature_scan_unit
// Streams code bytes through a row of window cells and counts start positions
// where any configured wildcard byte pattern matches; reports on the last byte.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   tvalid / tready    tdata: code_byte; tuser: start_allowed;
//                                    tlast: final_byte
//  m_*       out  tvalid / tready    tdata: hit_offset, hit_count; tuser: status
//  cfg_*     in   valid / ready      cfg_index, cfg_data
//
//  One byte per cycle while s_tready is high; every cell compares its byte in the same cycle.
//  The final byte's result is registered into m_*, or into the second slot while m_* holds a result not read then.
//  Two result slots: s_tready drops only while both hold unread results.
//  cfg_ready is always high. Reset clears all scan state and config registers, not the result data registers.
// ----------------------------------------------------------------------------
module wildcard_signature_scan_unit
    import wss_pkg::*;
#(
    parameter int PATTERN_BYTES = PATTERN_BYTES_DEF,
    parameter int PATTERN_COUNT = PATTERN_COUNT_DEF,
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [BYTE_W-1:0]                    s_tdata,   // [7:0] code_byte
    input  logic                                 s_tuser,   // [0] start_allowed
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [HIT_OFFSET_W+HIT_COUNT_W-1:0]  m_tdata,   // [31:0] hit_offset, [39:32] hit_count
    output logic [STATUS_W-1:0]                  m_tuser,   // [1:0] scan_status
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [CFG_INDEX_W-1:0]               cfg_index,
    input  logic [CFG_DATA_W-1:0]                cfg_data
);

    localparam int CELL_IDX_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

    logic [PAT_W-1:0]  pat_reg  [CFG_PATTERNS];
    logic [CARE_W-1:0] care_reg [CFG_PATTERNS];
    logic [LEN_W-1:0]  len_reg  [CFG_PATTERNS];

    logic step;
    logic clear;

    logic [PATTERN_COUNT-1:0]                    enable;
    logic [PATTERN_COUNT-1:0][CELL_IDX_W-1:0]    tap;
    logic [PATTERN_COUNT-1:0][BYTE_W-1:0]        cell_expect [PATTERN_BYTES];
    logic [PATTERN_COUNT-1:0]                    cell_care   [PATTERN_BYTES];
    logic [PATTERN_COUNT-1:0]                    cell_mis    [PATTERN_BYTES];
    logic [PATTERN_COUNT-1:0][PATTERN_BYTES-1:0] mismatch;

    logic [BYTE_W-1:0]        byte_in  [PATTERN_BYTES];
    logic [BYTE_W-1:0]        byte_q   [PATTERN_BYTES];
    logic [PATTERN_BYTES-1:0] allowed_in;
    logic [PATTERN_BYTES-1:0] allowed_q;
    logic [PATTERN_BYTES-1:0] counted_in;
    logic [PATTERN_BYTES-1:0] counted_q;
    logic [PATTERN_BYTES-1:0] set_counted;

    scan_result_t result;
    scan_result_t out_reg;
    scan_result_t out_next;
    scan_result_t skid_reg;
    scan_result_t skid_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    logic         push;
    logic         pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign step      = s_tvalid && s_tready;
    assign clear     = s_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < CFG_PATTERNS; p++)
            begin
                pat_reg[p]  <= '0;
                care_reg[p] <= '0;
                len_reg[p]  <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_P0_LOW:  pat_reg[0][63:0]   <= cfg_data;
                REG_P0_HIGH: pat_reg[0][127:64] <= cfg_data;
                REG_P1_LOW:  pat_reg[1][63:0]   <= cfg_data;
                REG_P1_HIGH: pat_reg[1][127:64] <= cfg_data;
                REG_P0_CARE: care_reg[0]        <= cfg_data[CARE_W-1:0];
                REG_P1_CARE: care_reg[1]        <= cfg_data[CARE_W-1:0];
                REG_P0_LEN:  len_reg[0]         <= cfg_data[LEN_W-1:0];
                REG_P1_LEN:  len_reg[1]         <= cfg_data[LEN_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        logic [LEN_W-1:0] len;
        int               last_idx;
        int               idx;
        for (int p = 0; p < PATTERN_COUNT; p++)
        begin
            len = '0;
            if (p < CFG_PATTERNS)
            begin
                len = len_reg[p];
            end
            enable[p] = (len != '0) && (int'(len) <= PATTERN_BYTES)
                        && (int'(len) <= REG_BYTES);
            last_idx  = int'(len) - 1;
            tap[p]    = CELL_IDX_W'(last_idx);
            for (int j = 0; j < PATTERN_BYTES; j++)
            begin
                idx = last_idx - j;
                cell_expect[j][p] = '0;
                cell_care[j][p]   = 1'b0;
                if (p < CFG_PATTERNS && idx >= 0 && idx < REG_BYTES)
                begin
                    cell_expect[j][p] = pattern_byte(pat_reg[p], 4'(idx));
                    cell_care[j][p]   = enable[p] && care_reg[p][4'(idx)];
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < PATTERN_BYTES; j++)
        begin
            if (j == 0)
            begin
                byte_in[j]    = s_tdata;
                allowed_in[j] = s_tuser;
                counted_in[j] = 1'b0;
            end
            else
            begin
                byte_in[j]    = byte_q[j-1];
                allowed_in[j] = allowed_q[j-1];
                counted_in[j] = counted_q[j-1];
            end
            for (int p = 0; p < PATTERN_COUNT; p++)
            begin
                mismatch[p][j] = cell_mis[j][p];
            end
        end
    end

    for (genvar j = 0; j < PATTERN_BYTES; j++)
    begin : g_cell
        wss_cell #(
            .PATTERN_COUNT (PATTERN_COUNT)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .step        (step),
            .clear       (clear),
            .in_byte     (byte_in[j]),
            .in_allowed  (allowed_in[j]),
            .in_counted  (counted_in[j]),
            .set_counted (set_counted[j]),
            .expect_byte (cell_expect[j]),
            .care        (cell_care[j]),
            .byte_q      (byte_q[j]),
            .allowed_q   (allowed_q[j]),
            .counted_q   (counted_q[j]),
            .mismatch    (cell_mis[j])
        );
    end

    wss_tally #(
        .PATTERN_BYTES (PATTERN_BYTES),
        .PATTERN_COUNT (PATTERN_COUNT),
        .OFFSET_BITS   (OFFSET_BITS),
        .CELL_IDX_W    (CELL_IDX_W)
    ) u_tally (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .last        (s_tlast),
        .enable      (enable),
        .tap         (tap),
        .mismatch    (mismatch),
        .allowed_in  (allowed_in),
        .counted_in  (counted_in),
        .set_counted (set_counted),
        .result      (result)
    );

    assign push = step && s_tlast;
    assign pop  = out_valid_reg && m_tready;

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        priority if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_next = push;
            if (push)
            begin
                out_next = result;
            end
        end
        else if (push)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.count, out_reg.offset};
    assign m_tuser  = out_reg.status;

endmodule
